FILE: rtl/core/pat_pkg.sv
// Shared types and constants for the peer access-control list table.
// Used by pat_front, pat_back and peer_acl_table_unit; depends on nothing.
package pat_pkg;

   localparam int DEF_MAX_GRANTS = 32;
   localparam int DEF_MAX_PEERS  = 8;

   localparam logic [2:0] PERM_READ    = 3'b001;
   localparam logic [2:0] PERM_CONTROL = 3'b010;

   // Command codes as carried on the input stream.
   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_REPLACE = 2'd1,
      CMD_ITEM    = 2'd2,
      CMD_AUTH    = 2'd3
   } cmd_type;

   // Finished-operation codes on the result stream.
   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_REPLACE = 2'd1,
      OP_AUTH    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // One classified input beat, as queued between front and back.
   typedef struct packed {
      cmd_type     kind;
      logic [2:0]  peer;
      logic [31:0] revision;
      logic [5:0]  count;
      logic [7:0]  rtype;
      logic [15:0] rid;
      logic [7:0]  perm;
      logic        bad;   // item: fails type/permission check; query: bad request bits
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DUP_RD,
      ST_DUP_EV,
      ST_AUTH_RD,
      ST_AUTH_EV,
      ST_FIN,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_SAME_RD,
      ST_SAME_EV,
      ST_CMP_RD,
      ST_CMP_EV,
      ST_APP_RD,
      ST_APP_WR,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/core/pat_front.sv
// Front end of the ACL table: accepts input beats, classifies them and
// holds them in a two-entry queue for the back end. Depends on pat_pkg.
module pat_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        channel_code,
   input  logic              in_valid,
   output logic              in_ready,
   input  pat_pkg::item_type in_item,
   output logic              q_valid,
   output pat_pkg::item_type q_item,
   input  logic              q_pop
);

   pat_pkg::item_type q_mem [2];
   pat_pkg::item_type cls_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   logic       perm_bad;

   assign in_ready = (fill_ff != 2'd2);
   assign q_valid  = (fill_ff != 2'd0);
   assign q_item   = q_mem[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   // Grant items must carry the channel type and a nonzero subset of the
   // three permission bits; queries need a nonzero subset as well.
   always_comb begin
      perm_bad = (in_item.perm == 8'd0) || (in_item.perm[7:3] != 5'd0);
      cls_item = in_item;
      case (in_item.kind)
         pat_pkg::CMD_ITEM: cls_item.bad = perm_bad || (in_item.rtype != channel_code);
         pat_pkg::CMD_AUTH: cls_item.bad = perm_bad;
         default:           cls_item.bad = 1'b0;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cls_item;
      end
   end

endmodule

FILE: rtl/core/pat_back.sv
// Back end of the ACL table: sequencer that stages, checks and commits grant
// lists and answers queries over the grant and staging memories. Depends on pat_pkg.
module pat_back #(
   parameter int MAX_GRANTS = pat_pkg::DEF_MAX_GRANTS,
   parameter int MAX_PEERS  = pat_pkg::DEF_MAX_PEERS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  pat_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pat_pkg::op_type   rsp_op,
   output logic              rsp_ok,
   output logic [2:0]        rsp_slot
);

   localparam int GW = $clog2(MAX_GRANTS + 1);
   localparam int GA = (MAX_GRANTS > 1) ? $clog2(MAX_GRANTS) : 1;
   localparam int PA = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int PT = $clog2(MAX_PEERS + 1);
   localparam int IW = (GW > 6) ? GW : 6;
   localparam int CW = IW + 1;
   localparam int SW = 27;
   localparam int EW = SW + PA;
   localparam int LW = 9;

   // Memories.
   logic [EW-1:0] gs_mem [MAX_GRANTS];
   logic [SW-1:0] st_mem [MAX_GRANTS];
   logic [EW-1:0] gs_q;
   logic [SW-1:0] st_q;
   logic          gs_we, st_we;
   logic [GA-1:0] gs_waddr, gs_raddr, st_waddr, st_raddr;
   logic [EW-1:0] gs_wdata;
   logic [SW-1:0] st_wdata;

   // Control and table state.
   pat_pkg::state_type state_ff, state_in;
   pat_pkg::item_type  cur_ff, cur_in;
   logic [GW-1:0]  total_ff, total_in;
   logic [PT-1:0]  peers_ff, peers_in;
   logic [MAX_PEERS-1:0] used_ff, used_in;
   logic [31:0]    rev_ff [MAX_PEERS];
   logic [GW-1:0]  pcnt_ff [MAX_PEERS];
   logic           meta_we;
   logic [PA-1:0]  meta_addr;
   logic [31:0]    meta_rev;
   logic [GW-1:0]  meta_cnt;
   logic           pact_ff, pact_in;
   logic           prep_ff, prep_in;
   logic [2:0]     ppeer_ff, ppeer_in;
   logic [31:0]    prev_ff, prev_in;
   logic [5:0]     pcount_ff, pcount_in;
   logic [5:0]     got_ff, got_in;
   logic           bad_ff, bad_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [IW-1:0]  idx2_ff, idx2_in;
   logic           res_ok_ff, res_ok_in;
   logic [2:0]     res_slot_ff, res_slot_in;
   logic           rsp_valid_ff, rsp_valid_in;
   pat_pkg::op_type rsp_op_ff, rsp_op_in;
   logic           rsp_ok_ff, rsp_ok_in;
   logic [2:0]     rsp_slot_ff, rsp_slot_in;

   // Shared conditions.
   logic [PA-1:0] pp_addr;
   logic          live_cur, live_pend;
   logic          idx_lt_got, idx_lt_total, idx_lt_count, idx2_lt_total;
   logic          got_lt_max, last_item;
   logic          add_fail, rep_fail, rep_older, rep_equal, cnt_differs, new_overflow;
   logic [PA-1:0] gs_peer;
   logic [7:0]    gs_type, st_type;
   logic [15:0]   gs_id, st_id;
   logic [2:0]    gs_perm, st_perm;
   logic          gs_is_cur, gs_is_pend, auth_hit, auth_ok, same_entry;
   logic          out_free;

   assign pp_addr   = PA'(ppeer_ff);
   assign live_cur  = (LW'(cur_ff.peer) < LW'(peers_ff)) && (LW'(cur_ff.peer) < LW'(MAX_PEERS))
                      && used_ff[PA'(cur_ff.peer)];
   assign live_pend = (LW'(ppeer_ff) < LW'(peers_ff)) && (LW'(ppeer_ff) < LW'(MAX_PEERS))
                      && used_ff[pp_addr];

   assign idx_lt_got    = CW'(idx_ff) < CW'(got_ff);
   assign idx_lt_total  = CW'(idx_ff) < CW'(total_ff);
   assign idx_lt_count  = CW'(idx_ff) < CW'(pcount_ff);
   assign idx2_lt_total = CW'(idx2_ff) < CW'(total_ff);
   assign got_lt_max    = CW'(got_ff) < CW'(MAX_GRANTS);
   assign last_item     = (CW'(got_ff) + CW'(1)) >= CW'(pcount_ff);

   assign add_fail     = bad_ff || (LW'(peers_ff) >= LW'(MAX_PEERS))
                         || ((CW'(total_ff) + CW'(pcount_ff)) > CW'(MAX_GRANTS));
   assign rep_fail     = !live_pend || bad_ff;
   assign rep_older    = prev_ff < rev_ff[pp_addr];
   assign rep_equal    = prev_ff == rev_ff[pp_addr];
   assign cnt_differs  = CW'(pcnt_ff[pp_addr]) != CW'(pcount_ff);
   assign new_overflow = (CW'(total_ff) - CW'(pcnt_ff[pp_addr]) + CW'(pcount_ff))
                         > CW'(MAX_GRANTS);

   assign {gs_peer, gs_type, gs_id, gs_perm} = gs_q;
   assign {st_type, st_id, st_perm}          = st_q;
   assign gs_is_cur  = LW'(gs_peer) == LW'(cur_ff.peer);
   assign gs_is_pend = LW'(gs_peer) == LW'(ppeer_ff);
   assign auth_hit   = gs_is_cur && (gs_type == cur_ff.rtype) && (gs_id == cur_ff.rid);
   assign auth_ok    = (cur_ff.perm[2:0] == pat_pkg::PERM_READ)
                       ? ((gs_perm & (pat_pkg::PERM_READ | pat_pkg::PERM_CONTROL)) != 3'd0)
                       : ((gs_perm & cur_ff.perm[2:0]) == cur_ff.perm[2:0]);
   assign same_entry = (gs_type == st_type) && (gs_id == st_id) && (gs_perm == st_perm);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign q_pop     = (state_ff == pat_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_op    = rsp_op_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_slot  = rsp_slot_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pat_pkg::ST_IDLE: begin
            if (q_valid) begin
               case (q_item.kind)
                  pat_pkg::CMD_ADD, pat_pkg::CMD_REPLACE:
                     state_in = (q_item.count == 6'd0) ? pat_pkg::ST_FIN : pat_pkg::ST_IDLE;
                  pat_pkg::CMD_ITEM: begin
                     if (!pact_ff) state_in = pat_pkg::ST_IDLE;
                     else if (got_lt_max) state_in = pat_pkg::ST_DUP_RD;
                     else if (last_item) state_in = pat_pkg::ST_FIN;
                  end
                  default: state_in = pat_pkg::ST_AUTH_RD;
               endcase
            end
         end
         pat_pkg::ST_DUP_RD: begin
            if (idx_lt_got) state_in = pat_pkg::ST_DUP_EV;
            else state_in = last_item ? pat_pkg::ST_FIN : pat_pkg::ST_IDLE;
         end
         pat_pkg::ST_DUP_EV: state_in = pat_pkg::ST_DUP_RD;
         pat_pkg::ST_AUTH_RD: begin
            if (cur_ff.bad || !live_cur || !idx_lt_total) state_in = pat_pkg::ST_EMIT;
            else state_in = pat_pkg::ST_AUTH_EV;
         end
         pat_pkg::ST_AUTH_EV: state_in = auth_hit ? pat_pkg::ST_EMIT : pat_pkg::ST_AUTH_RD;
         pat_pkg::ST_FIN: begin
            if (!prep_ff) state_in = add_fail ? pat_pkg::ST_EMIT : pat_pkg::ST_ADD_RD;
            else if (rep_fail || rep_older) state_in = pat_pkg::ST_EMIT;
            else if (rep_equal) state_in = cnt_differs ? pat_pkg::ST_EMIT : pat_pkg::ST_SAME_RD;
            else state_in = new_overflow ? pat_pkg::ST_EMIT : pat_pkg::ST_CMP_RD;
         end
         pat_pkg::ST_ADD_RD: state_in = idx_lt_count ? pat_pkg::ST_ADD_WR : pat_pkg::ST_EMIT;
         pat_pkg::ST_ADD_WR: state_in = pat_pkg::ST_ADD_RD;
         pat_pkg::ST_SAME_RD: begin
            if (!idx_lt_count || !idx2_lt_total) state_in = pat_pkg::ST_EMIT;
            else state_in = pat_pkg::ST_SAME_EV;
         end
         pat_pkg::ST_SAME_EV: begin
            if (gs_is_pend && !same_entry) state_in = pat_pkg::ST_EMIT;
            else state_in = pat_pkg::ST_SAME_RD;
         end
         pat_pkg::ST_CMP_RD: state_in = idx_lt_total ? pat_pkg::ST_CMP_EV : pat_pkg::ST_APP_RD;
         pat_pkg::ST_CMP_EV: state_in = pat_pkg::ST_CMP_RD;
         pat_pkg::ST_APP_RD: state_in = idx_lt_count ? pat_pkg::ST_APP_WR : pat_pkg::ST_EMIT;
         pat_pkg::ST_APP_WR: state_in = pat_pkg::ST_APP_RD;
         pat_pkg::ST_EMIT:   state_in = out_free ? pat_pkg::ST_IDLE : pat_pkg::ST_EMIT;
         default:            state_in = pat_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory controls and results.
   always_comb begin
      cur_in      = cur_ff;
      total_in    = total_ff;
      peers_in    = peers_ff;
      used_in     = used_ff;
      meta_we     = 1'b0;
      meta_addr   = pp_addr;
      meta_rev    = prev_ff;
      meta_cnt    = GW'(pcount_ff);
      pact_in     = pact_ff;
      prep_in     = prep_ff;
      ppeer_in    = ppeer_ff;
      prev_in     = prev_ff;
      pcount_in   = pcount_ff;
      got_in      = got_ff;
      bad_in      = bad_ff;
      idx_in      = idx_ff;
      idx2_in     = idx2_ff;
      res_ok_in   = res_ok_ff;
      res_slot_in = res_slot_ff;
      gs_we       = 1'b0;
      gs_waddr    = GA'(idx2_ff);
      gs_wdata    = {PA'(ppeer_ff), st_q};
      gs_raddr    = GA'(idx_ff);
      st_we       = 1'b0;
      st_waddr    = GA'(got_ff);
      st_wdata    = {cur_ff.rtype, cur_ff.rid, cur_ff.perm[2:0]};
      st_raddr    = GA'(idx_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_op_in   = rsp_op_ff;
      rsp_ok_in   = rsp_ok_ff;
      rsp_slot_in = rsp_slot_ff;

      unique case (state_ff)
         pat_pkg::ST_IDLE: begin
            res_ok_in   = 1'b0;
            res_slot_in = 3'd0;
            idx_in      = '0;
            idx2_in     = '0;
            if (q_valid) begin
               cur_in = q_item;
               case (q_item.kind)
                  pat_pkg::CMD_ADD, pat_pkg::CMD_REPLACE: begin
                     pact_in   = 1'b1;
                     prep_in   = (q_item.kind == pat_pkg::CMD_REPLACE);
                     ppeer_in  = q_item.peer;
                     prev_in   = q_item.revision;
                     pcount_in = q_item.count;
                     got_in    = 6'd0;
                     bad_in    = CW'(q_item.count) > CW'(MAX_GRANTS);
                  end
                  pat_pkg::CMD_ITEM: begin
                     if (pact_ff) begin
                        bad_in = bad_ff || q_item.bad;
                        if (!got_lt_max) got_in = got_ff + 6'd1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         pat_pkg::ST_DUP_RD: begin
            if (!idx_lt_got) begin
               st_we  = 1'b1;
               got_in = got_ff + 6'd1;
            end
         end
         pat_pkg::ST_DUP_EV: begin
            if ((st_type == cur_ff.rtype) && (st_id == cur_ff.rid)) bad_in = 1'b1;
            idx_in = idx_ff + IW'(1);
         end
         pat_pkg::ST_AUTH_RD: ;
         pat_pkg::ST_AUTH_EV: begin
            if (auth_hit) res_ok_in = auth_ok;
            idx_in = idx_ff + IW'(1);
         end
         pat_pkg::ST_FIN: begin
            // The duplicate walk leaves the index at the count staged before the last item.
            pact_in = 1'b0;
            bad_in  = 1'b0;
            idx_in  = '0;
            if (!prep_ff && !add_fail) begin
               used_in[PA'(peers_ff)] = 1'b1;
               meta_we   = 1'b1;
               meta_addr = PA'(peers_ff);
            end
         end
         pat_pkg::ST_ADD_RD: begin
            if (!idx_lt_count) begin
               total_in    = total_ff + GW'(pcount_ff);
               peers_in    = peers_ff + PT'(1);
               res_ok_in   = 1'b1;
               res_slot_in = 3'(peers_ff);
            end
         end
         pat_pkg::ST_ADD_WR: begin
            gs_we    = 1'b1;
            gs_waddr = GA'(total_ff) + GA'(idx_ff);
            gs_wdata = {PA'(peers_ff), st_q};
            idx_in   = idx_ff + IW'(1);
         end
         pat_pkg::ST_SAME_RD: begin
            gs_raddr = GA'(idx2_ff);
            if (!idx_lt_count) res_ok_in = 1'b1;
         end
         pat_pkg::ST_SAME_EV: begin
            idx2_in = idx2_ff + IW'(1);
            if (gs_is_pend) idx_in = idx_ff + IW'(1);
         end
         pat_pkg::ST_CMP_RD: begin
            if (!idx_lt_total) idx_in = '0;
         end
         pat_pkg::ST_CMP_EV: begin
            if (!gs_is_pend) begin
               gs_we    = 1'b1;
               gs_wdata = gs_q;
               idx2_in  = idx2_ff + IW'(1);
            end
            idx_in = idx_ff + IW'(1);
         end
         pat_pkg::ST_APP_RD: begin
            if (!idx_lt_count) begin
               total_in  = GW'(idx2_ff);
               meta_we   = 1'b1;
               res_ok_in = 1'b1;
            end
         end
         pat_pkg::ST_APP_WR: begin
            gs_we   = 1'b1;
            idx_in  = idx_ff + IW'(1);
            idx2_in = idx2_ff + IW'(1);
         end
         pat_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_slot_in  = res_slot_ff;
               if (cur_ff.kind == pat_pkg::CMD_AUTH) rsp_op_in = pat_pkg::OP_AUTH;
               else if (prep_ff) rsp_op_in = pat_pkg::OP_REPLACE;
               else rsp_op_in = pat_pkg::OP_ADD;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pat_pkg::ST_IDLE;
         total_ff     <= '0;
         peers_ff     <= '0;
         used_ff      <= '0;
         pact_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         peers_ff     <= peers_in;
         used_ff      <= used_in;
         pact_ff      <= pact_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prep_ff     <= prep_in;
      ppeer_ff    <= ppeer_in;
      prev_ff     <= prev_in;
      pcount_ff   <= pcount_in;
      got_ff      <= got_in;
      idx_ff      <= idx_in;
      idx2_ff     <= idx2_in;
      res_ok_ff   <= res_ok_in;
      res_slot_ff <= res_slot_in;
      rsp_op_ff   <= rsp_op_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
      if (meta_we) begin
         rev_ff[meta_addr]  <= meta_rev;
         pcnt_ff[meta_addr] <= meta_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (gs_we) gs_mem[gs_waddr] <= gs_wdata;
      gs_q <= gs_mem[gs_raddr];
   end

   always_ff @(posedge clock) begin
      if (st_we) st_mem[st_waddr] <= st_wdata;
      st_q <= st_mem[st_raddr];
   end

endmodule

FILE: rtl/core/peer_acl_table_unit.sv
// Top level of the peer access-control list table.
// Instantiates pat_front and pat_back; depends on pat_pkg.
//
// This block keeps one shared list of grants (peer, resource type, resource id,
// permission bits) for up to MAX_PEERS peers and MAX_GRANTS grants. An add or
// replace header beat is followed by its grant item beats; the items are staged,
// checked, and committed or rejected as a whole after the last one, which then
// produces a single result beat. An authorize beat produces one result beat
// telling whether the peer's first matching grant allows the request. A header
// with a zero count completes at once. The front end accepts and classifies
// beats into a two-entry queue, so up to two beats are taken in while the back
// end works or a result waits on the output register. Work per beat is set by
// the grant and staging memories, whose reads are registered and whose writes
// use a separate address: the back end reads and then evaluates each stored
// entry it walks, in separate states. A header is taken at once; a grant item
// walks the items already staged; an authorize walks up to T stored grants;
// committing an add or a replace of n items walks the n staged items and, for
// a replace, up to all T stored grants; the emit state hands the result over.
// Write the channel type register only while the block is idle.
module peer_acl_table_unit #(
   parameter int MAX_GRANTS = pat_pkg::DEF_MAX_GRANTS,
   parameter int MAX_PEERS  = pat_pkg::DEF_MAX_PEERS
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: channel type code that every grant must carry.
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: peer_index[2:0], revision[34:3], entry_count[40:35],
   // resource_type[48:41], resource_id[64:49], perm_bits[72:65], zero fill.
   input  logic [79:0] req_tdata,
   // tuser: cmd[1:0].
   input  logic [1:0]  req_tuser,
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: ok[0], assigned_peer[3:1], zero fill.
   output logic [7:0]  rsp_tdata,
   // tuser: op_done[1:0].
   output logic [1:0]  rsp_tuser
);

   logic [7:0] channel_code_ff, channel_code_in;
   pat_pkg::item_type in_item, q_item;
   logic            q_valid, q_pop;
   pat_pkg::op_type rsp_op;
   logic            rsp_ok;
   logic [2:0]      rsp_slot;

   // The channel type register takes effect for items classified afterward.
   assign channel_code_in = csr_we ? csr_wdata : channel_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_code_ff <= 8'd0;
      end else begin
         channel_code_ff <= channel_code_in;
      end
   end

   // Unpack the beat; the classification flag is filled in by the front end.
   always_comb begin
      in_item.kind     = pat_pkg::cmd_type'(req_tuser);
      in_item.peer     = req_tdata[2:0];
      in_item.revision = req_tdata[34:3];
      in_item.count    = req_tdata[40:35];
      in_item.rtype    = req_tdata[48:41];
      in_item.rid      = req_tdata[64:49];
      in_item.perm     = req_tdata[72:65];
      in_item.bad      = 1'b0;
   end

   pat_front u_front (
      .clock        (clock),
      .reset        (reset),
      .channel_code (channel_code_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_item      (in_item),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop)
   );

   pat_back #(
      .MAX_GRANTS (MAX_GRANTS),
      .MAX_PEERS  (MAX_PEERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_op    (rsp_op),
      .rsp_ok    (rsp_ok),
      .rsp_slot  (rsp_slot)
   );

   assign rsp_tdata = {4'd0, rsp_slot, rsp_ok};
   assign rsp_tuser = rsp_op;

endmodule

FILE: tb/sv/peer_acl_table_unit_tb.sv
// Testbench for peer_acl_table_unit: drives header, grant item and authorize beats,
// predicts every result beat from its own model of the grant list, and checks them.
// Depends on pat_pkg and the peer_acl_table_unit RTL.
module peer_acl_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NGRANT = 32;
   localparam int NPEER  = 8;
   localparam logic [7:0] PERM_MASK = 8'h07;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;

   peer_acl_table_unit u_top (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // One request beat as the stimulus sees it.
   typedef struct {
      pat_pkg::cmd_type cmd;
      logic [2:0]  peer;
      logic [31:0] rev;
      logic [5:0]  count;
      logic [7:0]  rtype;
      logic [15:0] rid;
      logic [7:0]  perm;
   } beat_type;

   // One expected result beat.
   typedef struct {
      pat_pkg::op_type op;
      logic       ok;
      logic [2:0] slot;
   } verdict_type;

   typedef struct {
      logic [7:0]  rtype;
      logic [15:0] rid;
      logic [2:0]  perm;
      logic [2:0]  peer;
   } grant_type;

   beat_type    pending_beats[$];
   verdict_type expected_verdicts[$];
   int          error_count;

   // Shadow of the table.
   logic [7:0]  chan_type;
   grant_type   acl[NGRANT];
   int          acl_total;
   int          peer_count;
   bit          slot_used[NPEER];
   logic [31:0] slot_rev[NPEER];
   int          slot_grants[NPEER];
   grant_type   staged[NGRANT];
   bit          hdr_active;
   pat_pkg::cmd_type hdr_cmd;
   logic [2:0]  hdr_peer;
   logic [31:0] hdr_rev;
   int          hdr_count;
   int          hdr_got;
   bit          hdr_bad;

   function automatic bit slot_live(int p);
      return p < peer_count && slot_used[p];
   endfunction

   function automatic bit list_matches(int p);
      int c;
      c = 0;
      if (slot_grants[p] != hdr_count) return 0;
      for (int i = 0; i < hdr_count; i++) begin
         while (c < acl_total && acl[c].peer != p) c++;
         if (c >= acl_total || acl[c].rtype != staged[i].rtype ||
             acl[c].rid != staged[i].rid || acl[c].perm != staged[i].perm)
            return 0;
         c++;
      end
      return 1;
   endfunction

   // Commits the staged list and returns the result of the header operation.
   function automatic verdict_type commit_list();
      verdict_type v;
      int n;
      grant_type g;
      v.slot = 0;
      v.ok = 0;
      if (hdr_cmd == pat_pkg::CMD_ADD) begin
         v.op = pat_pkg::OP_ADD;
         if (!hdr_bad && peer_count < NPEER && acl_total + hdr_count <= NGRANT) begin
            slot_used[peer_count] = 1;
            slot_rev[peer_count] = hdr_rev;
            slot_grants[peer_count] = hdr_count;
            for (int i = 0; i < hdr_count; i++) begin
               g = staged[i];
               g.peer = peer_count[2:0];
               acl[acl_total++] = g;
            end
            v.ok = 1;
            v.slot = peer_count[2:0];
            peer_count++;
         end
      end else begin
         v.op = pat_pkg::OP_REPLACE;
         if (slot_live(hdr_peer) && !hdr_bad && hdr_rev >= slot_rev[hdr_peer]) begin
            if (hdr_rev == slot_rev[hdr_peer]) begin
               v.ok = list_matches(hdr_peer);
            end else if (acl_total - slot_grants[hdr_peer] + hdr_count <= NGRANT) begin
               n = 0;
               for (int i = 0; i < acl_total; i++)
                  if (acl[i].peer != hdr_peer) acl[n++] = acl[i];
               for (int i = 0; i < hdr_count; i++) begin
                  g = staged[i];
                  g.peer = hdr_peer;
                  acl[n++] = g;
               end
               slot_grants[hdr_peer] = hdr_count;
               slot_rev[hdr_peer] = hdr_rev;
               acl_total = n;
               v.ok = 1;
            end
         end
      end
      hdr_active = 0;
      hdr_bad = 0;
      return v;
   endfunction

   function automatic bit access_allowed(beat_type b);
      if (b.perm == 0 || (b.perm & ~PERM_MASK) != 0 || !slot_live(b.peer)) return 0;
      for (int i = 0; i < acl_total; i++) begin
         if (acl[i].peer != b.peer || acl[i].rtype != b.rtype || acl[i].rid != b.rid)
            continue;
         if (b.perm[2:0] == pat_pkg::PERM_READ)
            return (acl[i].perm & (pat_pkg::PERM_READ | pat_pkg::PERM_CONTROL)) != 0;
         return (acl[i].perm & b.perm[2:0]) == b.perm[2:0];
      end
      return 0;
   endfunction

   // Advances the shadow table by one accepted beat and queues any result.
   task automatic predict_beat(beat_type b);
      verdict_type v;
      bit dup;
      case (b.cmd)
         pat_pkg::CMD_ADD, pat_pkg::CMD_REPLACE: begin
            hdr_active = 1;
            hdr_cmd = b.cmd;
            hdr_peer = b.peer;
            hdr_rev = b.rev;
            hdr_count = b.count;
            hdr_got = 0;
            hdr_bad = b.count > NGRANT;
            if (b.count == 0) expected_verdicts.push_back(commit_list());
         end
         pat_pkg::CMD_ITEM: begin
            if (hdr_active) begin
               if (b.rtype != chan_type || b.perm == 0 || (b.perm & ~PERM_MASK) != 0)
                  hdr_bad = 1;
               if (hdr_got < NGRANT) begin
                  dup = 0;
                  for (int i = 0; i < hdr_got; i++)
                     if (staged[i].rtype == b.rtype && staged[i].rid == b.rid) dup = 1;
                  if (dup) hdr_bad = 1;
                  staged[hdr_got].rtype = b.rtype;
                  staged[hdr_got].rid = b.rid;
                  staged[hdr_got].perm = b.perm[2:0];
                  staged[hdr_got].peer = 0;
               end
               hdr_got++;
               if (hdr_got >= hdr_count) expected_verdicts.push_back(commit_list());
            end
         end
         default: begin
            v.op = pat_pkg::OP_AUTH;
            v.ok = access_allowed(b);
            v.slot = 0;
            expected_verdicts.push_back(v);
         end
      endcase
   endtask

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   // Driver: holds a beat on the bus until it is taken, with random gaps between beats.
   int  gap_left;
   bit  have_beat;
   beat_type cur_beat;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         have_beat = 0;
         gap_left = 0;
      end else begin
         if (!have_beat && pending_beats.size() > 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               cur_beat = pending_beats.pop_front();
               have_beat = 1;
               gap_left = $urandom_range(0, 3);
               req_tdata <= {7'd0, cur_beat.perm, cur_beat.rid, cur_beat.rtype,
                             cur_beat.count, cur_beat.rev, cur_beat.peer};
               req_tuser <= cur_beat.cmd;
            end
         end
         req_tvalid <= have_beat;
      end
   end

   // Acceptance is seen at the rising edge; the driver drops the beat afterwards.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_beat(cur_beat);
         have_beat = 0;
      end
   end

   // Receiver back-pressure, redrawn after each result beat.
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   // Monitor: compares each result beat with the oldest expected verdict.
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected result op=%0d", rsp_tuser));
         end else begin
            v = expected_verdicts.pop_front();
            if (rsp_tuser !== v.op)
               report_mismatch($sformatf("op %0d, expected %0d", rsp_tuser, v.op));
            if (rsp_tdata[0] !== v.ok)
               report_mismatch($sformatf("ok %0b, expected %0b", rsp_tdata[0], v.ok));
            if (rsp_tdata[3:1] !== v.slot)
               report_mismatch($sformatf("slot %0d, expected %0d", rsp_tdata[3:1], v.slot));
            if (rsp_tdata[7:4] !== 4'd0)
               report_mismatch("nonzero fill bits in result");
         end
         stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      end
   end

   function automatic beat_type mk(pat_pkg::cmd_type c, int p, logic [31:0] r, int n,
                                   logic [7:0] t, logic [15:0] id, logic [7:0] pm);
      beat_type b;
      b.cmd = c; b.peer = p[2:0]; b.rev = r; b.count = n[5:0];
      b.rtype = t; b.rid = id; b.perm = pm;
      return b;
   endfunction

   // Waits for every queued beat to go in and every result to come back.
   task automatic drain();
      while (pending_beats.size() > 0 || have_beat || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_chan_type(logic [7:0] v);
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      chan_type = v;
   endtask

   // A mostly well-formed list for the current channel type, sometimes damaged.
   task automatic queue_list(pat_pkg::cmd_type c, int p, logic [31:0] r, int n);
      logic [7:0]  t;
      logic [15:0] id;
      logic [7:0]  pm;
      pending_beats.push_back(mk(c, p, r, n, $urandom, $urandom, $urandom));
      for (int i = 0; i < n; i++) begin
         t = chan_type;
         id = $urandom_range(0, 40);
         pm = $urandom_range(1, 7);
         case ($urandom_range(0, 29))
            0: t = $urandom;
            1: pm = $urandom;
            2: pm = 0;
            default: ;
         endcase
         pending_beats.push_back(mk(pat_pkg::CMD_ITEM, $urandom, $urandom, $urandom,
                                    t, id, pm));
         if ($urandom_range(0, 15) == 0)
            pending_beats.push_back(mk(pat_pkg::CMD_AUTH, $urandom_range(0, 7), $urandom,
                                       $urandom, chan_type, $urandom_range(0, 40),
                                       $urandom_range(1, 7)));
      end
   endtask

   initial begin
      logic [7:0] ctab[4];
      int r;
      reset = 1;
      csr_we = 0;
      csr_wdata = 0;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = pat_pkg::CMD_ADD;
      rsp_tready = 0;
      error_count = 0;
      chan_type = 0;
      acl_total = 0;
      peer_count = 0;
      hdr_active = 0;
      hdr_bad = 0;
      hdr_got = 0;
      hdr_count = 0;
      foreach (slot_used[i]) begin
         slot_used[i] = 0;
         slot_rev[i] = 0;
         slot_grants[i] = 0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part with the reset channel type of zero.
      pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 0, 0, 1));    // stray item
      pending_beats.push_back(mk(pat_pkg::CMD_AUTH, 0, 0, 0, 0, 0, 1));    // unused slot
      pending_beats.push_back(mk(pat_pkg::CMD_ADD, 7, 32'hFFFF_FFFF, 0, 0, 0, 0)); // empty add
      pending_beats.push_back(mk(pat_pkg::CMD_ADD, 0, 5, 2, 0, 0, 0));
      pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 0, 16'hFFFF, 2));
      pending_beats.push_back(mk(pat_pkg::CMD_AUTH, 1, 0, 0, 0, 16'hFFFF, 1)); // read via control
      pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 0, 0, 7));
      pending_beats.push_back(mk(pat_pkg::CMD_AUTH, 1, 0, 0, 0, 0, 8'hFF)); // bad bits
      pending_beats.push_back(mk(pat_pkg::CMD_AUTH, 1, 0, 0, 0, 16'hFFFF, 6)); // needs all bits
      pending_beats.push_back(mk(pat_pkg::CMD_AUTH, 1, 0, 0, 0, 0, 0));    // zero bits
      pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 8'hFF, 1, 1)); // wrong type
      pending_beats.push_back(mk(pat_pkg::CMD_REPLACE, 1, 4, 1, 0, 0, 0)); // older revision
      pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 0, 1, 1));
      pending_beats.push_back(mk(pat_pkg::CMD_REPLACE, 1, 5, 2, 0, 0, 0)); // equal, same list
      pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 0, 16'hFFFF, 2));
      pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 0, 0, 7));
      pending_beats.push_back(mk(pat_pkg::CMD_REPLACE, 1, 6, 2, 0, 0, 0)); // duplicate pair
      pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 0, 3, 1));
      pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 0, 3, 4));
      pending_beats.push_back(mk(pat_pkg::CMD_REPLACE, 1, 9, 3, 0, 0, 0)); // dropped by next
      pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 0, 9, 1));
      pending_beats.push_back(mk(pat_pkg::CMD_REPLACE, 1, 9, 63, 0, 0, 0)); // count too large
      for (int i = 0; i < 63; i++)
         pending_beats.push_back(mk(pat_pkg::CMD_ITEM, 0, 0, 0, 0, i, 1));
      pending_beats.push_back(mk(pat_pkg::CMD_REPLACE, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
      drain();

      // Random phases, each under its own channel type.
      ctab[0] = 8'hFF; ctab[1] = 8'h5A; ctab[2] = 8'hA5; ctab[3] = 8'h00;
      for (int ph = 0; ph < 4; ph++) begin
         write_chan_type(ctab[ph]);
         for (int k = 0; k < 65; k++) begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
               queue_list(pat_pkg::CMD_ADD, $urandom, $urandom_range(0, 20),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 33)
                                                      : $urandom_range(0, 4));
            end else if (r < 6) begin
               queue_list(pat_pkg::CMD_REPLACE, $urandom_range(0, 7),
                          ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 25),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 34)
                                                      : $urandom_range(0, 5));
            end else if (r < 9) begin
               pending_beats.push_back(mk(pat_pkg::CMD_AUTH, $urandom_range(0, 7), $urandom,
                                          $urandom,
                                          ($urandom_range(0, 5) == 0) ? $urandom : ctab[ph],
                                          $urandom_range(0, 40),
                                          ($urandom_range(0, 5) == 0) ? $urandom
                                                                      : $urandom_range(1, 7)));
            end else begin
               pending_beats.push_back(mk(pat_pkg::cmd_type'($urandom_range(0, 3)), $urandom,
                                          $urandom, $urandom, $urandom, $urandom, $urandom));
            end
         end
         // Finish any list left open by noise so the block is idle for the write.
         if (hdr_active || pending_beats.size() > 0)
            pending_beats.push_back(mk(pat_pkg::CMD_ADD, 0, 0, 0, 0, 0, 0));
         drain();
      end

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
